// File: rtl/rphr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rphr_pkg;
    localparam int HUE_FRAC = 6;
    localparam int UNIT_FRAC = 16;
    localparam int HUE_W = 15;
    localparam int UNIT_W = UNIT_FRAC + 1;
    localparam int DIV_STEPS = 17;
    localparam logic [HUE_W-1:0] HUE_SECTOR = HUE_W'(60 << HUE_FRAC);
    localparam logic [HUE_W-1:0] HUE_FULL = HUE_W'(360 << HUE_FRAC);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pix_t;

    // One pipeline beat between cells.
    typedef struct packed {
        logic              vld;
        logic [7:0]        mx;
        logic [7:0]        delta;
        logic [1:0]        sel;
        logic              neg;
        logic [21:0]       rem;
        logic [HUE_W-1:0]  quo;
        logic [UNIT_W-1:0] v;
        logic [UNIT_W-1:0] s;
        logic [23:0]       srem;
        logic [HUE_W-1:0]  hoff;
    } beat_t;
endpackage
`default_nettype wire

// File: rtl/rphr_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module rphr_div_cell
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  en,
    input  wire  rphr_pkg::beat_t din,
    output rphr_pkg::beat_t dout
);
    import rphr_pkg::*;

    rphr_pkg::beat_t dout_reg;
    rphr_pkg::beat_t dout_next;
    logic [8:0] hdiff;
    logic [8:0] sdiff;

    // One restoring step of both dividers: hue divides by delta, saturation by max.
    always_comb
    begin
        dout_next = din;
        hdiff = din.rem[21:13] - {1'b0, din.delta};
        if (!hdiff[8])
        begin
            dout_next.rem = {hdiff[7:0], din.rem[12:0], 1'b0};
            dout_next.quo = {din.quo[HUE_W-2:0], 1'b1};
        end
        else
        begin
            dout_next.rem = {din.rem[20:0], 1'b0};
            dout_next.quo = {din.quo[HUE_W-2:0], 1'b0};
        end
        sdiff = din.srem[23:15] - {1'b0, din.mx};
        if (!sdiff[8])
        begin
            dout_next.srem = {sdiff[7:0], din.srem[14:0], 1'b0};
            dout_next.s = {din.s[UNIT_W-2:0], 1'b1};
        end
        else
        begin
            dout_next.srem = {din.srem[22:0], 1'b0};
            dout_next.s = {din.s[UNIT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg.vld <= 1'b0;
        else if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;
endmodule
`default_nettype wire

// File: rtl/rphr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rphr_front
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  en,
    input  wire  vld_in,
    input  wire  rphr_pkg::pix_t pix,
    input  wire  [rphr_pkg::HUE_W-1:0] hoff,
    output rphr_pkg::beat_t dout
);
    import rphr_pkg::*;

    rphr_pkg::beat_t dout_reg;
    rphr_pkg::beat_t dout_next;
    logic [7:0] mx;
    logic [7:0] mn;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] mag;
    logic [13:0] num;
    logic [HUE_W-1:0] hmod;

    always_comb
    begin
        mx = pix.r;
        mn = pix.r;
        if (pix.g > mx) mx = pix.g;
        if (pix.b > mx) mx = pix.b;
        if (pix.g < mn) mn = pix.g;
        if (pix.b < mn) mn = pix.b;
        dout_next = '0;
        dout_next.vld = vld_in;
        dout_next.mx = mx;
        dout_next.delta = mx - mn;
        if (mx == pix.r)
        begin
            dout_next.sel = 2'd0;
            a = pix.g;
            b = pix.b;
        end
        else if (mx == pix.g)
        begin
            dout_next.sel = 2'd1;
            a = pix.b;
            b = pix.r;
        end
        else
        begin
            dout_next.sel = 2'd2;
            a = pix.r;
            b = pix.g;
        end
        dout_next.neg = (a < b);
        mag = dout_next.neg ? b - a : a - b;
        // The top bits of 60*mag*64 start as the partial remainder, the rest shift in.
        num = {6'd0, mag} * 14'd60;
        dout_next.rem = {5'd0, num, 3'd0};
        dout_next.srem = {1'b0, dout_next.delta, 15'd0};
        // v = ceil(max * 2^16 / 255) = max*257 plus one when max is nonzero.
        if (mx == 8'd0)
            dout_next.v = '0;
        else
            dout_next.v = {1'b0, mx, mx} + 17'd1;
        hmod = (hoff >= HUE_FULL) ? hoff - HUE_FULL : hoff;
        dout_next.hoff = hmod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg.vld <= 1'b0;
        else if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;
endmodule
`default_nettype wire

// File: rtl/rphr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rphr_back
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  en,
    input  wire  rphr_pkg::beat_t din,
    output logic vld_out,
    output rphr_pkg::pix_t pix
);
    import rphr_pkg::*;

    logic [HUE_W:0] hs;
    logic [HUE_W-1:0] hq;
    logic [HUE_W-1:0] base;
    logic [HUE_W:0] hsum;
    logic [HUE_W-1:0] h;
    logic [33:0] vs;

    logic s1_vld_reg;
    logic s1_gray_reg;
    logic [HUE_W-1:0] s1_h_reg;
    logic [UNIT_W-1:0] s1_v_reg;
    logic [UNIT_W-1:0] s1_c_reg;

    logic [2:0] k;
    logic [HUE_W-1:0] f;
    logic [HUE_W-1:0] t;
    logic [HUE_W-1:0] edge_h;

    logic s2_vld_reg;
    logic s2_gray_reg;
    logic [2:0] s2_k_reg;
    logic [UNIT_W-1:0] s2_v_reg;
    logic [UNIT_W-1:0] s2_c_reg;
    logic [31:0] s2_ct_reg;

    logic [UNIT_W-1:0] x;
    logic [UNIT_W-1:0] m;
    logic [UNIT_W:0] cr;
    logic [UNIT_W:0] cg;
    logic [UNIT_W:0] cb;
    pix_t pix_next;
    pix_t pix_reg;
    logic vld_reg;

    function automatic logic [7:0] to_ch(input logic [UNIT_W:0] u);
        logic [UNIT_W+8:0] p;
        begin
            p = {u, 8'd0} - {8'd0, u};
            to_ch = (p[UNIT_W+8:UNIT_FRAC] > 10'd255) ? 8'd255 : p[UNIT_FRAC+7:UNIT_FRAC];
        end
    endfunction

    always_comb
    begin
        hq = din.quo;
        unique case (din.sel)
            2'd0: base = '0;
            2'd1: base = HUE_W'(120 << HUE_FRAC);
            default: base = HUE_W'(240 << HUE_FRAC);
        endcase
        if (din.delta == 8'd0)
            hs = '0;
        else if (din.neg)
            hs = {1'b0, base} + {1'b0, HUE_FULL} - {1'b0, hq};
        else
            hs = {1'b0, base} + {1'b0, hq};
        if (hs >= {1'b0, HUE_FULL}) hs = hs - {1'b0, HUE_FULL};
        hsum = hs + {1'b0, din.hoff};
        if (hsum >= {1'b0, HUE_FULL}) hsum = hsum - {1'b0, HUE_FULL};
        h = hsum[HUE_W-1:0];
        vs = {17'd0, din.v} * {17'd0, din.s};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= din.vld;
            s2_vld_reg <= s1_vld_reg;
            vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_gray_reg <= (din.s == '0);
            s1_h_reg <= h;
            s1_v_reg <= din.v;
            s1_c_reg <= UNIT_W'(vs >> UNIT_FRAC);
        end
    end

    always_comb
    begin
        k = 3'd5;
        edge_h = HUE_W'(5 * HUE_SECTOR);
        if (s1_h_reg < HUE_SECTOR)
        begin
            k = 3'd0;
            edge_h = '0;
        end
        else if (s1_h_reg < HUE_W'(2 * HUE_SECTOR))
        begin
            k = 3'd1;
            edge_h = HUE_SECTOR;
        end
        else if (s1_h_reg < HUE_W'(3 * HUE_SECTOR))
        begin
            k = 3'd2;
            edge_h = HUE_W'(2 * HUE_SECTOR);
        end
        else if (s1_h_reg < HUE_W'(4 * HUE_SECTOR))
        begin
            k = 3'd3;
            edge_h = HUE_W'(3 * HUE_SECTOR);
        end
        else if (s1_h_reg < HUE_W'(5 * HUE_SECTOR))
        begin
            k = 3'd4;
            edge_h = HUE_W'(4 * HUE_SECTOR);
        end
        f = s1_h_reg - edge_h;
        t = k[0] ? HUE_SECTOR - f : f;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_gray_reg <= s1_gray_reg;
            s2_k_reg <= k;
            s2_v_reg <= s1_v_reg;
            s2_c_reg <= s1_c_reg;
            s2_ct_reg <= {15'd0, s1_c_reg} * {20'd0, t[11:0]};
        end
    end

    // Divide by 3840 = 15 * 256: shift by 8, then divide a 24-bit value by 15.
    logic [23:0] q256;
    logic [47:0] qm;
    logic [UNIT_W-1:0] q15;
    always_comb
    begin
        q256 = s2_ct_reg[31:8];
        qm = {24'd0, q256} * 48'h888889;
        q15 = UNIT_W'(qm >> 27);
        x = q15;
        m = s2_v_reg - s2_c_reg;
        cr = '0;
        cg = '0;
        cb = '0;
        case (s2_k_reg)
            3'd0: begin cr = {1'b0, s2_c_reg}; cg = {1'b0, x}; end
            3'd1: begin cr = {1'b0, x}; cg = {1'b0, s2_c_reg}; end
            3'd2: begin cg = {1'b0, s2_c_reg}; cb = {1'b0, x}; end
            3'd3: begin cg = {1'b0, x}; cb = {1'b0, s2_c_reg}; end
            3'd4: begin cr = {1'b0, x}; cb = {1'b0, s2_c_reg}; end
            default: begin cr = {1'b0, s2_c_reg}; cb = {1'b0, x}; end
        endcase
        if (s2_gray_reg)
        begin
            pix_next.r = to_ch({1'b0, s2_v_reg});
            pix_next.g = pix_next.r;
            pix_next.b = pix_next.r;
        end
        else
        begin
            pix_next.r = to_ch(cr + {1'b0, m});
            pix_next.g = to_ch(cg + {1'b0, m});
            pix_next.b = to_ch(cb + {1'b0, m});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pix_reg <= pix_next;
    end

    assign vld_out = vld_reg;
    assign pix = pix_reg;
endmodule
`default_nettype wire

// File: rtl/rgb_pixel_hue_rotate.sv
// Hue rotation of an RGB pixel stream.
// Slave channel s_axis_*: one pixel per beat, tdata = red, green, blue from bit 0.
// Master channel m_axis_*: the rotated pixel, packed the same way.
// hue_offset_we/hue_offset_wdata load the rotation in 1/64 degree; it is
// reduced modulo 360 degrees and should only change while the stream is idle.
// The pipeline is a front cell (max, min, delta, value), a chain of seventeen
// restoring divider cells that retire one quotient bit each for hue and
// saturation, and three back stages (hue sum and chroma, sector product,
// divide and pack).
// Throughput is one pixel per cycle unless the receiver stalls the output.
// The whole chain advances together; when the receiver stalls with a valid
// output, the chain halts and s_axis_tready falls, so nothing is dropped.
// Reset clears all valid flags and sets the hue offset to zero.
`timescale 1ns / 1ps
`default_nettype none
module rgb_pixel_hue_rotate
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         hue_offset_we,
    input  wire  [14:0] hue_offset_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,  // red_in, green_in, blue_in
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata   // red_out, green_out, blue_out
);
    import rphr_pkg::*;

    logic [HUE_W-1:0] hoff_reg;
    logic en;
    pix_t pin;
    pix_t pout;
    beat_t chain [DIV_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hoff_reg <= '0;
        else if (hue_offset_we)
            hoff_reg <= hue_offset_wdata;
    end

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign pin.r = s_axis_tdata[7:0];
    assign pin.g = s_axis_tdata[15:8];
    assign pin.b = s_axis_tdata[23:16];

    rphr_front u_front
    (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(s_axis_tvalid),
        .pix(pin), .hoff(hoff_reg), .dout(chain[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        rphr_div_cell u_cell
        (
            .clk(clk), .rst_n(rst_n), .en(en), .din(chain[i]), .dout(chain[i+1])
        );
    end

    rphr_back u_back
    (
        .clk(clk), .rst_n(rst_n), .en(en), .din(chain[DIV_STEPS]),
        .vld_out(m_axis_tvalid), .pix(pout)
    );

    assign m_axis_tdata = {pout.b, pout.g, pout.r};
endmodule
`default_nettype wire

// File: rtl/rphr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rphr_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken during output stall");
endmodule

bind rgb_pixel_hue_rotate rphr_checker u_rphr_checker
(
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;
    import rphr_pkg::*;

    localparam int LATENCY = 21;
    localparam int STALL_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        hue_offset_we = 1'b0;
    logic [14:0] hue_offset_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       has_exp;
        logic [7:0] er;
        logic [7:0] eg;
        logic [7:0] eb;
    } row_t;

    logic [14:0] rot_offset = '0;
    logic [23:0] pending_pixels [$];
    int          errors = 0;
    int          pixels_sent = 0;
    int          pixels_checked = 0;
    int          idle_cycles = 0;
    int          ready_gap = 0;
    bit          calm = 1'b0;
    bit          stall_timeout = 1'b0;
    row_t        directed [$];

    rgb_pixel_hue_rotate u_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .hue_offset_we    (hue_offset_we),
        .hue_offset_wdata (hue_offset_wdata),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata)
    );

    always #10 clk = ~clk;

    function automatic longint unsigned to_chan(longint unsigned u);
        longint unsigned ch;
        ch = (u * 255) >> UNIT_FRAC;
        return (ch > 255) ? 255 : ch;
    endfunction

    function automatic longint unsigned sector_hue(longint unsigned base_deg,
        longint unsigned a, longint unsigned b, longint unsigned delta);
        longint unsigned full;
        longint unsigned q;
        full = 360 << HUE_FRAC;
        if (a < b)
        begin
            q = ((60 * (b - a)) << HUE_FRAC) / delta;
            return ((base_deg << HUE_FRAC) + full - q) % full;
        end
        q = ((60 * (a - b)) << HUE_FRAC) / delta;
        return ((base_deg << HUE_FRAC) + q) % full;
    endfunction

    // Packs red in the low byte, as the port comment says.
    function automatic logic [23:0] rotate_pixel(logic [23:0] pix, logic [14:0] offs);
        longint unsigned r, g, b, mx, mn, delta, v, s, h, c, x, m, k, f, t;
        longint unsigned sec, full, cr, cg, cb;
        r = pix[7:0];
        g = pix[15:8];
        b = pix[23:16];
        sec = 60 << HUE_FRAC;
        full = 360 << HUE_FRAC;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        v = (mx * (64'd1 << UNIT_FRAC) + 254) / 255;
        s = (mx == 0) ? 0 : (delta * (64'd1 << UNIT_FRAC)) / mx;
        if (delta == 0) h = 0;
        else if (mx == r) h = sector_hue(0, g, b, delta);
        else if (mx == g) h = sector_hue(120, b, r, delta);
        else h = sector_hue(240, r, g, delta);
        h = (h + offs % full) % full;
        if (s == 0)
        begin
            cr = to_chan(v);
            return {cr[7:0], cr[7:0], cr[7:0]};
        end
        c = (v * s) >> UNIT_FRAC;
        m = v - c;
        k = h / sec;
        f = h % sec;
        t = k[0] ? sec - f : f;
        x = (c * t) / sec;
        case (k)
            0: begin cr = c; cg = x; cb = 0; end
            1: begin cr = x; cg = c; cb = 0; end
            2: begin cr = 0; cg = c; cb = x; end
            3: begin cr = 0; cg = x; cb = c; end
            4: begin cr = x; cg = 0; cb = c; end
            default: begin cr = c; cg = 0; cb = x; end
        endcase
        cr = to_chan(cr + m);
        cg = to_chan(cg + m);
        cb = to_chan(cb + m);
        return {cb[7:0], cg[7:0], cr[7:0]};
    endfunction

    task automatic send_pixel(logic [23:0] pix);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_pixels.push_back(rotate_pixel(pix, rot_offset));
        pixels_sent++;
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic load_offset(logic [14:0] offs);
        hue_offset_we <= 1'b1;
        hue_offset_wdata <= offs;
        @(posedge clk);
        hue_offset_we <= 1'b0;
        rot_offset = offs;
        @(posedge clk);
    endtask

    function automatic logic [23:0] random_pixel();
        logic [23:0] p;
        p = 24'($urandom);
        case ($urandom_range(0, 9))
            0: p[15:8] = p[7:0];
            1: p[23:16] = p[15:8];
            2: p = {p[7:0], p[7:0], p[7:0]};
            3: p[23:16] = p[7:0];
            default: ;
        endcase
        return p;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (calm)
            begin
                ready_gap <= 0;
                m_axis_tready <= 1'b1;
            end
            else if (ready_gap != 0)
            begin
                ready_gap <= ready_gap - 1;
                m_axis_tready <= (ready_gap == 1);
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                ready_gap <= $urandom_range(1, 9);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        logic [23:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected output beat %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (m_axis_tdata[7:0] !== want[7:0])
                begin
                    $error("red_out expected %0d actual %0d", want[7:0], m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[15:8] !== want[15:8])
                begin
                    $error("green_out expected %0d actual %0d", want[15:8],
                        m_axis_tdata[15:8]);
                    errors++;
                end
                if (m_axis_tdata[23:16] !== want[23:16])
                begin
                    $error("blue_out expected %0d actual %0d", want[23:16],
                        m_axis_tdata[23:16]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !stall_timeout)
        begin
            stall_timeout = 1'b1;
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [23:0] got;
        logic [14:0] offsets [8];
        directed.push_back('{8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0});
        directed.push_back('{8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255});
        directed.push_back('{8'd128, 8'd128, 8'd128, 1'b1, 8'd128, 8'd128, 8'd128});
        directed.push_back('{8'd255, 8'd0, 8'd0, 1'b1, 8'd255, 8'd0, 8'd0});
        directed.push_back('{8'd0, 8'd255, 8'd0, 1'b1, 8'd0, 8'd255, 8'd0});
        directed.push_back('{8'd0, 8'd0, 8'd255, 1'b1, 8'd0, 8'd0, 8'd255});
        directed.push_back('{8'd255, 8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0});
        directed.push_back('{8'd0, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0});
        directed.push_back('{8'd255, 8'd0, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0});
        directed.push_back('{8'd200, 8'd200, 8'd10, 1'b0, 8'd0, 8'd0, 8'd0});
        directed.push_back('{8'd10, 8'd200, 8'd200, 1'b0, 8'd0, 8'd0, 8'd0});
        directed.push_back('{8'd200, 8'd10, 8'd200, 1'b0, 8'd0, 8'd0, 8'd0});
        directed.push_back('{8'd1, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0});
        directed.push_back('{8'd255, 8'd254, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0});
        directed.push_back('{8'd12, 8'd200, 8'd77, 1'b0, 8'd0, 8'd0, 8'd0});
        directed.push_back('{8'd90, 8'd30, 8'd250, 1'b0, 8'd0, 8'd0, 8'd0});
        offsets = '{15'd0, 15'd23039, 15'd32767, 15'd23040, 15'd3840, 15'd11520,
            15'd1, 15'd17000};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_pixel({directed[i].b, directed[i].g, directed[i].r});
            if (directed[i].has_exp)
            begin
                got = rotate_pixel({directed[i].b, directed[i].g, directed[i].r}, 15'd0);
                if (got !== {directed[i].eb, directed[i].eg, directed[i].er})
                begin
                    $error("predictor row %0d expected %h actual %h", i,
                        {directed[i].eb, directed[i].eg, directed[i].er}, got);
                    errors++;
                end
            end
        end
        drain_pipeline();

        foreach (offsets[p])
        begin
            load_offset(p == 7 ? 15'($urandom) : offsets[p]);
            foreach (directed[i])
                send_pixel({directed[i].b, directed[i].g, directed[i].r});
            for (int n = 0; n < 210; n++)
            begin
                if (p == 7 && n > 120) calm = 1'b1;
                send_pixel(random_pixel());
            end
            drain_pipeline();
        end

        $display("Sent %0d pixels over %0d hue offsets, %0d outputs checked.",
            pixels_sent, 9, pixels_checked);
        if (errors == 0 && pending_pixels.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
